[rtl/assert_macros.svh]
// assertion macros for the port-level checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

[rtl/opat_pkg.sv]
// types, constants and helpers for the alarm table
// no dependencies
package opat_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int OP_W   = 2;
    localparam int TIME_W = 32;
    localparam int PER_W  = 31;
    localparam int ID_W   = 8;
    localparam int STAT_W = 2;
    localparam int ENT_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_AT    = 2'd1,
        OP_EVERY = 2'd2,
        OP_RSVD  = 2'd3
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_FIRED = 2'd0,
        ST_NONE  = 2'd1,
        ST_SCHED = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0] due;
        logic [PER_W-1:0]  per;
        logic [ID_W-1:0]   id;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // add an interval to a time, clamping at the largest time
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [PER_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {{(TIME_W + 1 - PER_W){1'b0}}, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

[rtl/opat_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module opat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/oneshot_periodic_alarm_table.sv]
// alarm table: one-shot and periodic alarms held in insertion order
// uses opat_pkg and opat_ram (entry table and fired-id buffer)
// schedule beat: result loaded via S_RESP into the output register; tick over n entries:
// scan through the entry ram read port, then one fired result per cycle while not stalled
// one input beat at a time; next beat taken while the final result still waits
// reset clears control state and the entry count; ram contents stay undefined
module oneshot_periodic_alarm_table #(
    parameter int MAX_TASKS = opat_pkg::MAX_TASKS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [opat_pkg::OP_W-1:0]    opcode,
    input  logic [opat_pkg::TIME_W-1:0]  now_time,
    input  logic [opat_pkg::TIME_W-1:0]  due_time,
    input  logic [opat_pkg::PER_W-1:0]   period,
    input  logic [opat_pkg::ID_W-1:0]    task_id,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [opat_pkg::STAT_W-1:0]  status,
    output logic [opat_pkg::ID_W-1:0]    fired_id,
    output logic                         last,
    output logic [opat_pkg::ENT_W-1:0]   entries_in_use
);

    import opat_pkg::*;

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               chk_reg, chk_next;
    logic [CNT_W-1:0]   wr_idx_reg, wr_idx_next;
    logic [CNT_W-1:0]   nf_reg, nf_next;
    logic [CNT_W-1:0]   em_idx_reg, em_idx_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    status_t            res_status_reg, res_status_next;
    logic [ID_W-1:0]    res_id_reg, res_id_next;

    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [ID_W-1:0]    out_id_reg, out_id_next;
    logic               out_last_reg, out_last_next;
    logic [ENT_W-1:0]   out_ent_reg, out_ent_next;

    logic               ent_we, ent_re;
    logic [IDX_W-1:0]   ent_waddr, ent_raddr;
    logic [ENTRY_W-1:0] ent_wdata, ent_rdata;
    logic               fire_we, fire_re;
    logic [IDX_W-1:0]   fire_waddr, fire_raddr;
    logic [ID_W-1:0]    fire_wdata, fire_rdata;

    entry_t             ent_cur, ent_new;
    logic               hit;
    logic               out_free;
    logic               em_last;
    logic [CNT_W-1:0]   em_inc;
    logic               accept;
    opcode_t            op;

    opat_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS),
        .AW    (IDX_W)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    opat_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_TASKS),
        .AW    (IDX_W)
    ) u_fire_ram (
        .clk   (clk),
        .we    (fire_we),
        .waddr (fire_waddr),
        .wdata (fire_wdata),
        .re    (fire_re),
        .raddr (fire_raddr),
        .rdata (fire_rdata)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign op       = opcode_t'(opcode);
    assign out_free = !out_valid_reg || !out_stall;
    assign ent_cur  = entry_t'(ent_rdata);
    assign hit      = chk_reg && (now_reg >= ent_cur.due);
    assign em_inc   = em_idx_reg + CNT_W'(1);
    assign em_last  = (em_idx_reg == (nf_reg - CNT_W'(1)));

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        chk_next        = chk_reg;
        wr_idx_next     = wr_idx_reg;
        nf_next         = nf_reg;
        em_idx_next     = em_idx_reg;
        now_next        = now_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;

        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_last_next   = out_last_reg;
        out_ent_next    = out_ent_reg;

        ent_we     = 1'b0;
        ent_waddr  = count_reg[IDX_W-1:0];
        ent_new    = '{due: due_time, per: '0, id: task_id};
        ent_re     = 1'b0;
        ent_raddr  = '0;
        fire_we    = 1'b0;
        fire_waddr = nf_reg[IDX_W-1:0];
        fire_wdata = ent_cur.id;
        fire_re    = 1'b0;
        fire_raddr = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    now_next = now_time;
                    unique case (op) inside
                        OP_AT, OP_EVERY:
                        begin
                            res_id_next = task_id;
                            state_next  = S_RESP;
                            if (count_reg >= CNT_W'(MAX_TASKS))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                res_status_next = ST_SCHED;
                                ent_we          = 1'b1;
                                if (op == OP_EVERY)
                                begin
                                    ent_new = '{due: sat_add(now_time, period),
                                                per: period, id: task_id};
                                end
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_TICK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_NONE;
                                res_id_next     = '0;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                ent_re      = 1'b1;
                                rd_idx_next = CNT_W'(1);
                                chk_next    = 1'b1;
                                wr_idx_next = '0;
                                nf_next     = '0;
                                state_next  = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (chk_reg)
                begin
                    // fired entries queue their id; survivors close up at the write index
                    if (hit)
                    begin
                        fire_we = 1'b1;
                        nf_next = nf_reg + CNT_W'(1);
                    end
                    ent_new   = ent_cur;
                    if (hit)
                    begin
                        ent_new.due = sat_add(ent_cur.due, ent_cur.per);
                    end
                    ent_waddr = wr_idx_reg[IDX_W-1:0];
                    if (!hit || (ent_cur.per != '0))
                    begin
                        ent_we      = 1'b1;
                        wr_idx_next = wr_idx_reg + CNT_W'(1);
                    end
                    if (rd_idx_reg < count_reg)
                    begin
                        ent_re      = 1'b1;
                        ent_raddr   = rd_idx_reg[IDX_W-1:0];
                        rd_idx_next = rd_idx_reg + CNT_W'(1);
                        chk_next    = 1'b1;
                    end
                    else
                    begin
                        chk_next = 1'b0;
                    end
                end
                else
                begin
                    count_next = wr_idx_reg;
                    if (nf_reg == '0)
                    begin
                        res_status_next = ST_NONE;
                        res_id_next     = '0;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        fire_re     = 1'b1;
                        em_idx_next = '0;
                        state_next  = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_FIRED;
                    out_id_next     = fire_rdata;
                    out_last_next   = em_last;
                    out_ent_next    = ENT_W'(count_reg);
                    if (em_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        fire_re     = 1'b1;
                        fire_raddr  = em_inc[IDX_W-1:0];
                        em_idx_next = em_inc;
                    end
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_id_next     = res_id_reg;
                    out_last_next   = 1'b1;
                    out_ent_next    = ENT_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        ent_wdata = ent_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            chk_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            chk_reg       <= chk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        wr_idx_reg     <= wr_idx_next;
        nf_reg         <= nf_next;
        em_idx_reg     <= em_idx_next;
        now_reg        <= now_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_last_reg   <= out_last_next;
        out_ent_reg    <= out_ent_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign fired_id       = out_id_reg;
    assign last           = out_last_reg;
    assign entries_in_use = out_ent_reg;

endmodule

[rtl/opat_checker.sv]
// port-level checks for the alarm table, bound to the top level
// uses opat_pkg and assert_macros.svh
`include "assert_macros.svh"

module opat_checker #(
    parameter int MAX_TASKS = opat_pkg::MAX_TASKS_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic [opat_pkg::OP_W-1:0]    opcode,
    input logic [opat_pkg::TIME_W-1:0]  now_time,
    input logic [opat_pkg::TIME_W-1:0]  due_time,
    input logic [opat_pkg::PER_W-1:0]   period,
    input logic [opat_pkg::ID_W-1:0]    task_id,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [opat_pkg::STAT_W-1:0]  status,
    input logic [opat_pkg::ID_W-1:0]    fired_id,
    input logic                         last,
    input logic [opat_pkg::ENT_W-1:0]   entries_in_use
);

    import opat_pkg::*;

    logic [STAT_W+ID_W+ENT_W:0] out_beat;

    assign out_beat = {status, fired_id, last, entries_in_use};

    // stalled result beat holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_beat))

    // only fired beats come in bursts
    `ASSERT_IMPLY(a_single_last, clk, rst_n, out_valid && (status != ST_FIRED), last)

    // no new item while a burst of fired beats is still going
    `ASSERT_IMPLY(a_burst_stall, clk, rst_n, out_valid && !last, in_stall)

    // a burst has no gaps once a beat is taken
    `ASSERT_NEXT(a_burst_cont, clk, rst_n, out_valid && !out_stall && !last, out_valid)

    `ASSERT_IMPLY(a_count_cap, clk, rst_n, out_valid, entries_in_use <= MAX_TASKS)

endmodule

bind oneshot_periodic_alarm_table opat_checker #(.MAX_TASKS(MAX_TASKS)) u_opat_checker (.*);

[dv/opat_checker.sv]
`timescale 1ns / 1ps
// watches both channels of the alarm table, predicts each result beat and compares it
// depends on opat_pkg for widths and the opcode and status enums
module opat_scoreboard #(
    parameter int MAX_TASKS = opat_pkg::MAX_TASKS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [opat_pkg::OP_W-1:0]   opcode,
    input  logic [opat_pkg::TIME_W-1:0] now_time,
    input  logic [opat_pkg::TIME_W-1:0] due_time,
    input  logic [opat_pkg::PER_W-1:0]  period,
    input  logic [opat_pkg::ID_W-1:0]   task_id,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [opat_pkg::STAT_W-1:0] status,
    input  logic [opat_pkg::ID_W-1:0]   fired_id,
    input  logic                        last,
    input  logic [opat_pkg::ENT_W-1:0]  entries_in_use,
    output int                          fail_count,
    output int                          results_owed
);

    import opat_pkg::*;

    typedef struct packed {
        status_t          st;
        logic [ID_W-1:0]  id;
        logic             fin;
        logic [ENT_W-1:0] used;
    } alarm_result_t;

    logic [TIME_W-1:0] alarm_due [MAX_TASKS];
    logic [PER_W-1:0]  alarm_per [MAX_TASKS];
    logic [ID_W-1:0]   alarm_id  [MAX_TASKS];
    int                alarm_cnt;
    alarm_result_t     pending_results [$];
    alarm_result_t     head;

    // time plus interval, pinned at the largest time on overflow
    function automatic logic [TIME_W-1:0] clamp_add(input logic [TIME_W-1:0] t,
                                                    input logic [PER_W-1:0] p);
        logic [TIME_W:0] sum;
        sum = {1'b0, t} + {1'b0, {(TIME_W - PER_W){1'b0}}, p};
        if (sum[TIME_W])
            return '1;
        return sum[TIME_W-1:0];
    endfunction

    task automatic add_alarm(input logic [TIME_W-1:0] due, input logic [PER_W-1:0] per,
                             input logic [ID_W-1:0] id);
        if (alarm_cnt >= MAX_TASKS)
        begin
            pending_results.push_back('{ST_FULL, id, 1'b1, ENT_W'(alarm_cnt)});
        end
        else
        begin
            alarm_due[alarm_cnt] = due;
            alarm_per[alarm_cnt] = per;
            alarm_id[alarm_cnt]  = id;
            alarm_cnt++;
            pending_results.push_back('{ST_SCHED, id, 1'b1, ENT_W'(alarm_cnt)});
        end
    endtask

    task automatic run_tick(input logic [TIME_W-1:0] now);
        logic [ID_W-1:0] fired [$];
        int              kept;
        bit              keep;
        kept = 0;
        for (int r = 0; r < alarm_cnt; r++)
        begin
            keep = 1'b1;
            if (now >= alarm_due[r])
            begin
                fired.push_back(alarm_id[r]);
                if (alarm_per[r] != '0)
                    alarm_due[r] = clamp_add(alarm_due[r], alarm_per[r]);
                else
                    keep = 1'b0;
            end
            // survivors close up toward the front, order kept
            if (keep)
            begin
                alarm_due[kept] = alarm_due[r];
                alarm_per[kept] = alarm_per[r];
                alarm_id[kept]  = alarm_id[r];
                kept++;
            end
        end
        alarm_cnt = kept;
        if (fired.size() == 0)
            pending_results.push_back('{ST_NONE, '0, 1'b1, ENT_W'(alarm_cnt)});
        for (int k = 0; k < fired.size(); k++)
            pending_results.push_back('{ST_FIRED, fired[k], k == fired.size() - 1,
                                        ENT_W'(alarm_cnt)});
    endtask

    task automatic check_field(input string what, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_cnt = 0;
            pending_results.delete();
            fail_count = 0;
            results_owed = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                case (opcode)
                    OP_TICK:  run_tick(now_time);
                    OP_AT:    add_alarm(due_time, '0, task_id);
                    OP_EVERY: add_alarm(clamp_add(now_time, period), period, task_id);
                    default:  ;  // reserved code: no state change, no beat
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result beat with none expected, actual status %0d id %0d",
                             $time, status, fired_id);
                    fail_count++;
                end
                else
                begin
                    head = pending_results.pop_front();
                    check_field("status", head.st, status);
                    check_field("fired_id", head.id, fired_id);
                    check_field("last", head.fin, last);
                    check_field("entries_in_use", head.used, entries_in_use);
                end
            end
            results_owed = pending_results.size();
        end
    end

endmodule

[dv/tb_oneshot_periodic_alarm_table.sv]
`timescale 1ns / 1ps
// top of the alarm table bench: clock, reset, request stimulus, result stall and verdict
// depends on opat_pkg, oneshot_periodic_alarm_table and opat_scoreboard
module tb_oneshot_periodic_alarm_table;
    import opat_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_ITEMS   = 335;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [OP_W-1:0]   opcode;
    logic [TIME_W-1:0] now_time;
    logic [TIME_W-1:0] due_time;
    logic [PER_W-1:0]  period;
    logic [ID_W-1:0]   task_id;
    logic              out_valid;
    logic              out_stall;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   fired_id;
    logic              last;
    logic [ENT_W-1:0]  entries_in_use;
    int                fail_count;
    int                results_owed;
    logic              quiet;
    logic              hold_start;

    oneshot_periodic_alarm_table i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .now_time       (now_time),
        .due_time       (due_time),
        .period         (period),
        .task_id        (task_id),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .fired_id       (fired_id),
        .last           (last),
        .entries_in_use (entries_in_use)
    );

    opat_scoreboard i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .now_time       (now_time),
        .due_time       (due_time),
        .period         (period),
        .task_id        (task_id),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .fired_id       (fired_id),
        .last           (last),
        .entries_in_use (entries_in_use),
        .fail_count     (fail_count),
        .results_owed   (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic send_request(input opcode_t op, input logic [TIME_W-1:0] now,
                                input logic [TIME_W-1:0] due, input logic [PER_W-1:0] per,
                                input logic [ID_W-1:0] id);
        while (!quiet && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        now_time <= now;
        due_time <= due;
        period   <= per;
        task_id  <= id;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // result side: random stall, one long hold-off when asked
    initial
    begin
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_start && !hold_used)
            begin
                hold_left = HOLD_CYCLES;
                hold_used = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= !quiet && ($urandom_range(99) < 13);
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        logic [TIME_W-1:0] clock_now;
        logic [PER_W-1:0]  per;
        int                pick;
        int                periodic_budget;
        opcode_t           op;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        opcode     <= OP_TICK;
        now_time   <= '0;
        due_time   <= '0;
        period     <= '0;
        task_id    <= '0;
        quiet      <= 1'b0;
        hold_start <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, then field extremes and the overflow cases
        send_request(OP_TICK, '0, '1, '1, 8'hFF);
        send_request(OP_AT, '1, '0, '0, 8'h00);
        send_request(OP_AT, '0, '1, '1, 8'hFF);
        send_request(OP_EVERY, 32'hFFFF_FFF0, '0, 31'h7FFF_FFFF, 8'h5A);
        send_request(OP_EVERY, 32'd10, '1, '0, 8'hA5);
        send_request(OP_EVERY, 32'd5, '0, 31'd3, 8'h33);
        send_request(OP_RSVD, '1, '1, '1, 8'hC3);
        send_request(OP_TICK, '0, '0, '0, 8'h00);
        send_request(OP_TICK, 32'd9, '0, '0, 8'h00);
        send_request(OP_TICK, '1, '0, '0, 8'h00);
        // saturated periodic entry fires again on the next tick at max time
        send_request(OP_TICK, '1, '0, '0, 8'h00);
        for (int k = 0; k < 14; k++)
            send_request(OP_AT, $urandom, 32'd100 + k, 31'($urandom), 8'(k + 16));
        send_request(OP_EVERY, '0, '0, '0, 8'h77);

        clock_now = '0;
        periodic_budget = 6;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 60)
                hold_start <= 1'b1;
            if (n == 150)
                quiet <= 1'b1;
            if (n == 230)
                quiet <= 1'b0;
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                case ($urandom_range(2))
                    0:       op = OP_TICK;
                    1:       op = OP_AT;
                    default: op = OP_RSVD;
                endcase
                send_request(op, $urandom, $urandom, 31'($urandom), 8'($urandom));
            end
            else if (pick < 45)
            begin
                pick = $urandom_range(99);
                if (pick < 3)
                    clock_now = $urandom;
                else if (pick < 6)
                    clock_now = 32'hFFFF_FFFF - $urandom_range(20);
                else
                    clock_now = clock_now + $urandom_range(16);
                send_request(OP_TICK, clock_now, $urandom, 31'($urandom), 8'($urandom));
            end
            else if (pick < 75)
                send_request(OP_AT, $urandom, clock_now + $urandom_range(40),
                             31'($urandom), 8'($urandom));
            else
            begin
                // periodic entries never leave the table, so keep them few
                if (periodic_budget > 0 && $urandom_range(3) == 0)
                begin
                    per = 31'($urandom_range(30, 1));
                    periodic_budget--;
                end
                else
                    per = '0;
                send_request(OP_EVERY, ($urandom_range(9) == 0) ? $urandom : clock_now,
                             $urandom, per, 8'($urandom));
            end
        end
        in_valid <= 1'b0;

        // let the checker register the final accepted beat first
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0 && results_owed == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
